### hw/rtl/sca_pkg.sv
// Package with the scan code constants, the key map tables and shared types.
`default_nettype none
package sca_pkg;

  localparam logic [7:0] PrefixCode = 8'hE0;
  localparam logic [6:0] LShiftCode = 7'h2A;
  localparam logic [6:0] RShiftCode = 7'h36;
  localparam logic [6:0] CapsCode   = 7'h3A;
  localparam logic [6:0] LetterLow  = 7'h61;
  localparam logic [6:0] LetterHigh = 7'h7A;

  typedef struct packed {
    logic       emit;
    logic [6:0] ascii_char;
  } sca_dec_t;

  function automatic logic [6:0] rom_plain(input logic [6:0] code);
    logic [6:0] ch;
    unique case (code)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] rom_shift(input logic [6:0] code);
    logic [6:0] ch;
    unique case (code)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h21;
      7'd3:    ch = 7'h40;
      7'd4:    ch = 7'h23;
      7'd5:    ch = 7'h24;
      7'd6:    ch = 7'h25;
      7'd7:    ch = 7'h5E;
      7'd8:    ch = 7'h26;
      7'd9:    ch = 7'h2A;
      7'd10:   ch = 7'h28;
      7'd11:   ch = 7'h29;
      7'd12:   ch = 7'h5F;
      7'd13:   ch = 7'h2B;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h51;
      7'd17:   ch = 7'h57;
      7'd18:   ch = 7'h45;
      7'd19:   ch = 7'h52;
      7'd20:   ch = 7'h54;
      7'd21:   ch = 7'h59;
      7'd22:   ch = 7'h55;
      7'd23:   ch = 7'h49;
      7'd24:   ch = 7'h4F;
      7'd25:   ch = 7'h50;
      7'd26:   ch = 7'h7B;
      7'd27:   ch = 7'h7D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h41;
      7'd31:   ch = 7'h53;
      7'd32:   ch = 7'h44;
      7'd33:   ch = 7'h46;
      7'd34:   ch = 7'h47;
      7'd35:   ch = 7'h48;
      7'd36:   ch = 7'h4A;
      7'd37:   ch = 7'h4B;
      7'd38:   ch = 7'h4C;
      7'd39:   ch = 7'h3A;
      7'd40:   ch = 7'h22;
      7'd41:   ch = 7'h7E;
      7'd43:   ch = 7'h7C;
      7'd44:   ch = 7'h5A;
      7'd45:   ch = 7'h58;
      7'd46:   ch = 7'h43;
      7'd47:   ch = 7'h56;
      7'd48:   ch = 7'h42;
      7'd49:   ch = 7'h4E;
      7'd50:   ch = 7'h4D;
      7'd51:   ch = 7'h3C;
      7'd52:   ch = 7'h3E;
      7'd53:   ch = 7'h3F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sca_code_if.sv
// Interface for the scan code input channel.
`default_nettype none
interface sca_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink (input valid, input scan_code, output ready);
endinterface
`default_nettype wire

### hw/rtl/sca_char_if.sv
// Interface for the ASCII character output channel.
`default_nettype none
interface sca_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink (input valid, input ascii_char, output ready);
endinterface
`default_nettype wire

### hw/rtl/scancode_to_ascii_decoder.sv
// Scan codes pass the single input register, characters the single output register.
// Throughput: one scan code per cycle while the output is not stalled.
// Bytes that give no character leave the input register even while the output stalls.
// Reset clears the shift, caps lock and prefix flags and both valid registers.
// Top level of the scan code set 1 to ASCII decoder.
`default_nettype none
module scancode_to_ascii_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  sca_code_if.sink    code_i,
  sca_char_if.source  char_o
);
  import sca_pkg::*;

  logic       in_valid;
  logic [7:0] in_code;
  logic       advance;
  logic       space;
  sca_dec_t   dec;

  assign advance = in_valid && (!dec.emit || space);

  sca_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (code_i.valid),
    .scan_code_i (code_i.scan_code),
    .advance_i   (advance),
    .ready_o     (code_i.ready),
    .valid_o     (in_valid),
    .scan_code_o (in_code)
  );

  sca_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_code_i (in_code),
    .fire_i      (advance),
    .dec_o       (dec)
  );

  sca_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && dec.emit),
    .dec_i        (dec),
    .ready_i      (char_o.ready),
    .space_o      (space),
    .valid_o      (char_o.valid),
    .ascii_char_o (char_o.ascii_char)
  );

endmodule
`default_nettype wire

### hw/rtl/sca_in_stage.sv
// Input register that holds one scan code byte until it is decoded.
`default_nettype none
module sca_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] scan_code_i,
  input  logic       advance_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] scan_code_o
);

  logic       valid_q, valid_d;
  logic [7:0] code_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      code_q <= scan_code_i;
    end
  end

  assign valid_o     = valid_q;
  assign scan_code_o = code_q;

endmodule
`default_nettype wire

### hw/rtl/sca_decode.sv
// Modifier flags and key map lookup for one scan code byte.
`default_nettype none
module sca_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        scan_code_i,
  input  logic              fire_i,
  output sca_pkg::sca_dec_t dec_o
);
  import sca_pkg::*;

  logic       lshift_q, lshift_d;
  logic       rshift_q, rshift_d;
  logic       caps_q, caps_d;
  logic       prefix_q, prefix_d;
  logic       released;
  logic [6:0] code;
  logic [6:0] plain_ch;
  logic [6:0] shift_ch;
  logic       is_letter;
  logic       shifted;
  logic       lookup;

  assign released  = scan_code_i[7];
  assign code      = scan_code_i[6:0];
  assign plain_ch  = rom_plain(code);
  assign shift_ch  = rom_shift(code);
  assign is_letter = (plain_ch >= LetterLow) && (plain_ch <= LetterHigh);
  assign shifted   = (lshift_q || rshift_q) ^ (caps_q && is_letter);

  always_comb begin
    lshift_d = lshift_q;
    rshift_d = rshift_q;
    caps_d   = caps_q;
    prefix_d = prefix_q;
    lookup   = 1'b0;
    if (scan_code_i == PrefixCode) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
    end else if (code == LShiftCode) begin
      lshift_d = !released;
    end else if (code == RShiftCode) begin
      rshift_d = !released;
    end else if (code == CapsCode) begin
      if (!released) begin
        caps_d = !caps_q;
      end
    end else begin
      lookup = !released;
    end
  end

  always_comb begin
    dec_o.ascii_char = shifted ? shift_ch : plain_ch;
    dec_o.emit       = lookup && (dec_o.ascii_char != 7'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (fire_i) begin
      lshift_q <= lshift_d;
      rshift_q <= rshift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.emit |-> (dec_o.ascii_char != 7'h00))
    else $error("Decoder emits a zero character.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (scan_code_i == PrefixCode) |=> prefix_q)
    else $error("Prefix byte did not set the prefix flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.emit |-> (!released && !prefix_q))
    else $error("Character emitted for a break code or a prefixed byte.");
`endif

endmodule
`default_nettype wire

### hw/rtl/sca_out_stage.sv
// Output register that holds one ASCII character until it is taken.
`default_nettype none
module sca_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sca_pkg::sca_dec_t dec_i,
  input  logic              ready_i,
  output logic              space_o,
  output logic              valid_o,
  output logic [6:0]        ascii_char_o
);
  import sca_pkg::*;

  logic       valid_q, valid_d;
  logic [6:0] char_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= dec_i.ascii_char;
    end
  end

  assign valid_o      = valid_q;
  assign ascii_char_o = char_q;

endmodule
`default_nettype wire
